### hw/rtl/lpg_pkg.sv
// lpg_pkg: field widths and controller/datapath interface structs for the
// lexicographic permutation generator; no dependencies
`default_nettype none

package lpg_pkg;

   localparam int ELEM_W = 4;   // element value
   localparam int POS_W  = 3;   // position field
   localparam int CNT_W  = 16;  // permutation count
   localparam int CFG_W  = 4;   // perm_len register

   localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

   // commands from the controller to the datapath
   typedef struct packed {
      logic init;        // back to identity, count one, started
      logic set_done;    // sequence exhausted
      logic piv_start;   // pivot scan from the end
      logic piv_rd;      // read entries i-1 and i
      logic piv_dec;
      logic piv_found;   // capture pivot index and value
      logic suc_rd;      // read entry j
      logic suc_dec;
      logic suc_found;   // capture successor value
      logic wr_pivot;    // successor value into pivot slot
      logic wr_succ;     // pivot value into successor slot
      logic rev_rd;      // read entries lo and hi
      logic rev_w1;      // hi value into lo slot
      logic rev_w2;      // lo value into hi slot, step pointers
      logic bump;        // saturating count increment
      logic emit_start;
      logic emit_rd;     // read entry k
      logic emit_next;
      logic show_exh;    // payload shows the exhausted item
   } lpg_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic started;
      logic done;
      logic len_one;     // effective length is one
      logic a_lt_b;      // read port a below read port b
      logic a_gt_pv;     // read port a above pivot value
      logic i_is_one;
      logic lo_lt_hi;
      logic k_last;
   } lpg_status_type;

endpackage

`default_nettype wire

### hw/rtl/lpg_datapath.sv
// lpg_datapath: permutation store, scan pointers, count and result payload
// depends on lpg_pkg
`default_nettype none

module lpg_datapath #(
   parameter int MAX_LEN = 8
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire lpg_pkg::lpg_cmd_type        cmd,
   output lpg_pkg::lpg_status_type          status,
   input  wire logic                        csr_write_enable,
   input  wire logic [lpg_pkg::CFG_W-1:0]   csr_write_data,
   output logic [lpg_pkg::ELEM_W-1:0]       rsp_element,
   output logic [lpg_pkg::POS_W-1:0]        rsp_position,
   output logic                             rsp_last,
   output logic                             rsp_exhausted,
   output logic [lpg_pkg::CNT_W-1:0]        rsp_perm_count
);

   localparam int IDX_W = $clog2(MAX_LEN);

   typedef logic [IDX_W-1:0]           idx_type;
   typedef logic [lpg_pkg::ELEM_W-1:0] elem_type;

   // clamp the written length to 1..MAX_LEN and keep it minus one
   function automatic idx_type len_m1_of(input logic [lpg_pkg::CFG_W-1:0] v);
      idx_type r;
      if (v == '0) begin
         r = '0;
      end else if (int'(v) > MAX_LEN) begin
         r = IDX_W'(MAX_LEN - 1);
      end else begin
         r = IDX_W'(v - lpg_pkg::CFG_W'(1));
      end
      return r;
   endfunction

   elem_type                 perm_mem [MAX_LEN];
   logic [MAX_LEN-1:0]       valid_ff;
   idx_type                  len_m1_ff;
   logic                     started_ff;
   logic                     done_ff;
   logic [lpg_pkg::CNT_W-1:0] count_ff;

   elem_type rd_a_ff, rd_b_ff, pv_ff, sv_ff;
   idx_type  i_ff, j_ff, p_ff, lo_ff, hi_ff, k_ff;

   idx_type  addr_a, addr_b, wr_addr;
   elem_type wr_data;
   logic     rd_en, wr_en;

   // read address selection
   always_comb begin
      addr_a = k_ff;
      addr_b = i_ff;
      rd_en  = cmd.piv_rd | cmd.suc_rd | cmd.rev_rd | cmd.emit_rd;
      priority if (cmd.piv_rd) begin
         addr_a = i_ff - IDX_W'(1);
         addr_b = i_ff;
      end else if (cmd.suc_rd) begin
         addr_a = j_ff;
      end else if (cmd.rev_rd) begin
         addr_a = lo_ff;
         addr_b = hi_ff;
      end else begin
         addr_a = k_ff;
      end
   end

   // write address and data selection
   always_comb begin
      wr_en   = cmd.wr_pivot | cmd.wr_succ | cmd.rev_w1 | cmd.rev_w2;
      wr_addr = p_ff;
      wr_data = sv_ff;
      priority if (cmd.wr_pivot) begin
         wr_addr = p_ff;
         wr_data = sv_ff;
      end else if (cmd.wr_succ) begin
         wr_addr = j_ff;
         wr_data = pv_ff;
      end else if (cmd.rev_w1) begin
         wr_addr = lo_ff;
         wr_data = rd_b_ff;
      end else begin
         wr_addr = hi_ff;
         wr_data = rd_a_ff;
      end
   end

   // permutation store, entries without a valid bit read as identity
   always_ff @(posedge clock) begin
      if (wr_en) begin
         perm_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= valid_ff[addr_a] ? perm_mem[addr_a]
                                     : lpg_pkg::ELEM_W'(addr_a) + lpg_pkg::ELEM_W'(1);
         rd_b_ff <= valid_ff[addr_b] ? perm_mem[addr_b]
                                     : lpg_pkg::ELEM_W'(addr_b) + lpg_pkg::ELEM_W'(1);
      end
   end

   // control state: length, valid bits, flags, count
   always_ff @(posedge clock) begin
      if (reset) begin
         len_m1_ff  <= len_m1_of(lpg_pkg::CFG_W'(3));
         valid_ff   <= '0;
         started_ff <= 1'b0;
         done_ff    <= 1'b0;
         count_ff   <= '0;
      end else if (csr_write_enable) begin
         len_m1_ff  <= len_m1_of(csr_write_data);
         valid_ff   <= '0;
         started_ff <= 1'b0;
         done_ff    <= 1'b0;
         count_ff   <= '0;
      end else begin
         if (cmd.init) begin
            valid_ff   <= '0;
            started_ff <= 1'b1;
            done_ff    <= 1'b0;
            count_ff   <= lpg_pkg::CNT_W'(1);
         end else if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (cmd.set_done) begin
            done_ff <= 1'b1;
         end
         if (cmd.bump && count_ff != lpg_pkg::COUNT_MAX) begin
            count_ff <= count_ff + lpg_pkg::CNT_W'(1);
         end
      end
   end

   // scan and emit pointers
   always_ff @(posedge clock) begin
      if (cmd.piv_start) i_ff <= len_m1_ff;
      if (cmd.piv_dec)   i_ff <= i_ff - IDX_W'(1);
      if (cmd.piv_found) begin
         p_ff  <= i_ff - IDX_W'(1);
         pv_ff <= rd_a_ff;
         j_ff  <= len_m1_ff;
      end
      if (cmd.suc_dec)   j_ff  <= j_ff - IDX_W'(1);
      if (cmd.suc_found) sv_ff <= rd_a_ff;
      if (cmd.wr_succ) begin
         lo_ff <= p_ff + IDX_W'(1);
         hi_ff <= len_m1_ff;
      end
      if (cmd.rev_w2) begin
         lo_ff <= lo_ff + IDX_W'(1);
         hi_ff <= hi_ff - IDX_W'(1);
      end
      if (cmd.emit_start) k_ff <= '0;
      if (cmd.emit_next)  k_ff <= k_ff + IDX_W'(1);
   end

   always_comb begin
      status.started  = started_ff;
      status.done     = done_ff;
      status.len_one  = (len_m1_ff == '0);
      status.a_lt_b   = (rd_a_ff < rd_b_ff);
      status.a_gt_pv  = (rd_a_ff > pv_ff);
      status.i_is_one = (i_ff == IDX_W'(1));
      status.lo_lt_hi = (lo_ff < hi_ff);
      status.k_last   = (k_ff == len_m1_ff);
   end

   // payload straight from the read register while the item is shown
   assign rsp_element    = cmd.show_exh ? '0 : rd_a_ff;
   assign rsp_position   = cmd.show_exh ? '0 : lpg_pkg::POS_W'(k_ff);
   assign rsp_last       = cmd.show_exh | (k_ff == len_m1_ff);
   assign rsp_exhausted  = cmd.show_exh;
   assign rsp_perm_count = count_ff;

endmodule

`default_nettype wire

### hw/rtl/lpg_controller.sv
// lpg_controller: sequencer for request decode, next-permutation steps and
// result emission; depends on lpg_pkg
`default_nettype none

module lpg_controller (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic                    req_restart,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   input  wire lpg_pkg::lpg_status_type status,
   output lpg_pkg::lpg_cmd_type         cmd
);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_PIV_RD   = 4'd1;
   localparam logic [3:0] ST_PIV_CMP  = 4'd2;
   localparam logic [3:0] ST_SUC_RD   = 4'd3;
   localparam logic [3:0] ST_SUC_CMP  = 4'd4;
   localparam logic [3:0] ST_SWAP_P   = 4'd5;
   localparam logic [3:0] ST_SWAP_S   = 4'd6;
   localparam logic [3:0] ST_REV_CHK  = 4'd7;
   localparam logic [3:0] ST_REV_RD   = 4'd8;
   localparam logic [3:0] ST_REV_W1   = 4'd9;
   localparam logic [3:0] ST_REV_W2   = 4'd10;
   localparam logic [3:0] ST_EMIT_RD  = 4'd11;
   localparam logic [3:0] ST_EMIT_OUT = 4'd12;
   localparam logic [3:0] ST_EXH_OUT  = 4'd13;

   logic [3:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT_OUT) || (state_ff == ST_EXH_OUT);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               priority if (req_restart || (!status.started && !status.done)) begin
                  cmd.init       = 1'b1;
                  cmd.emit_start = 1'b1;
                  state_in       = ST_EMIT_RD;
               end else if (status.done) begin
                  state_in = ST_EXH_OUT;
               end else if (status.len_one) begin
                  cmd.set_done = 1'b1;
                  state_in     = ST_EXH_OUT;
               end else begin
                  cmd.piv_start = 1'b1;
                  state_in      = ST_PIV_RD;
               end
            end
         end
         ST_PIV_RD: begin
            cmd.piv_rd = 1'b1;
            state_in   = ST_PIV_CMP;
         end
         ST_PIV_CMP: begin
            priority if (status.a_lt_b) begin
               cmd.piv_found = 1'b1;
               state_in      = ST_SUC_RD;
            end else if (status.i_is_one) begin
               cmd.set_done = 1'b1;
               state_in     = ST_EXH_OUT;
            end else begin
               cmd.piv_dec = 1'b1;
               state_in    = ST_PIV_RD;
            end
         end
         ST_SUC_RD: begin
            cmd.suc_rd = 1'b1;
            state_in   = ST_SUC_CMP;
         end
         ST_SUC_CMP: begin
            if (status.a_gt_pv) begin
               cmd.suc_found = 1'b1;
               state_in      = ST_SWAP_P;
            end else begin
               cmd.suc_dec = 1'b1;
               state_in    = ST_SUC_RD;
            end
         end
         ST_SWAP_P: begin
            cmd.wr_pivot = 1'b1;
            state_in     = ST_SWAP_S;
         end
         ST_SWAP_S: begin
            cmd.wr_succ = 1'b1;
            state_in    = ST_REV_CHK;
         end
         ST_REV_CHK: begin
            if (status.lo_lt_hi) begin
               state_in = ST_REV_RD;
            end else begin
               cmd.bump       = 1'b1;
               cmd.emit_start = 1'b1;
               state_in       = ST_EMIT_RD;
            end
         end
         ST_REV_RD: begin
            cmd.rev_rd = 1'b1;
            state_in   = ST_REV_W1;
         end
         ST_REV_W1: begin
            cmd.rev_w1 = 1'b1;
            state_in   = ST_REV_W2;
         end
         ST_REV_W2: begin
            cmd.rev_w2 = 1'b1;
            state_in   = ST_REV_CHK;
         end
         ST_EMIT_RD: begin
            cmd.emit_rd = 1'b1;
            state_in    = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            if (!rsp_stall) begin
               if (status.k_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.emit_next = 1'b1;
                  state_in      = ST_EMIT_RD;
               end
            end
         end
         ST_EXH_OUT: begin
            cmd.show_exh = 1'b1;
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### hw/rtl/lexicographic_permutation_generator.sv
// lexicographic_permutation_generator: top level joining the sequencer and
// the datapath; depends on lpg_pkg, lpg_controller, lpg_datapath
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_stall   req_restart
//   rsp      out  rsp_valid/rsp_stall   rsp_element, rsp_position, rsp_last,
//                                       rsp_exhausted, rsp_perm_count
//   csr      in   csr_write_enable      csr_write_data (perm_len)
//
// one request is worked at a time; req_stall is high from acceptance until
// its last item leaves. a restart or first request emits identity order; a
// next-permutation request runs the pivot and successor scans, the swap and
// the tail reversal, one write at a time through the single write port of
// the permutation store. the request that runs off the end makes a failed
// pivot scan over n-1 pairs; one after exhaustion shows the exhausted item.
// synchronous reset puts perm_len at 3 and the store at identity order
// through per-entry valid bits, so no clearing pass is needed.
// rsp_stall just holds the shown item; the sequencer waits on it.
`default_nettype none

module lexicographic_permutation_generator #(
   parameter int MAX_LEN = 8
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // request channel
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_restart,
   // result channel
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [lpg_pkg::ELEM_W-1:0]       rsp_element,
   output logic [lpg_pkg::POS_W-1:0]        rsp_position,
   output logic                             rsp_last,
   output logic                             rsp_exhausted,
   output logic [lpg_pkg::CNT_W-1:0]        rsp_perm_count,
   // configuration write port
   input  wire logic                        csr_write_enable,
   input  wire logic [lpg_pkg::CFG_W-1:0]   csr_write_data
);

   // command and status between sequencer and datapath
   lpg_pkg::lpg_cmd_type    cmd;
   lpg_pkg::lpg_status_type status;

   // sequencer: request decode, pivot and successor scans, tail reversal,
   // one item per element on the result side
   lpg_controller u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_restart (req_restart),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .status      (status),
      .cmd         (cmd)
   );

   // datapath: permutation store with two registered read ports, pointers,
   // saturating count and the result payload
   lpg_datapath #(
      .MAX_LEN (MAX_LEN)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_element      (rsp_element),
      .rsp_position     (rsp_position),
      .rsp_last         (rsp_last),
      .rsp_exhausted    (rsp_exhausted),
      .rsp_perm_count   (rsp_perm_count)
   );

endmodule

`default_nettype wire
